FILE: hdl/frame_peak_normalize_pack_core_defines.svh
// Assertion macros shared by the frame peak normalizer checker.
// Included by the checker file only; needs nothing else.
`ifndef FRAME_PEAK_NORMALIZE_PACK_CORE_DEFINES_SVH
`define FRAME_PEAK_NORMALIZE_PACK_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is active (active low).
`define FPNP_ASSERT_IMPLY(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is active (active low).
`define FPNP_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/fpnp_pkg.sv
// Shared types and constants of the frame peak normalizer.
// Used by the core and by its port checker; depends on nothing.
package fpnp_pkg;

    // Defaults for the core parameters
    localparam int MAX_WIDTH_DEF    = 256;
    localparam int MAX_HEIGHT_DEF   = 256;
    localparam int CHANNEL_BITS_DEF = 16;

    // Fixed field widths
    localparam int COORD_W     = 8;
    localparam int VALUE_W     = 16;
    localparam int WORD_W      = 32;
    localparam int PEAK_W      = 16;
    localparam int STATUS_W    = 2;
    localparam int FUNC_W      = 2;
    localparam int DIM_W       = 9;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 9;
    localparam int S_TDATA_W   = 64;
    localparam int M_TDATA_W   = 48;

    // Helper widths: dimension compare up to 8191, channels up to 32 bits
    localparam int DIM_EXT_W  = 13;
    localparam int CHAN_EXT_W = 32;
    localparam int BYTE_W     = 8;
    localparam int QUOT_W     = 8;

    // Item functions
    typedef enum logic [FUNC_W-1:0] {
        FUNC_WRITE = 2'd0,
        FUNC_SCAN  = 2'd1,
        FUNC_READ  = 2'd2
    } func_t;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK        = 2'd0,
        STATUS_RANGE     = 2'd1,
        STATUS_PEAK_ZERO = 2'd2
    } status_t;

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_FRAME_WIDTH  = 2'd0,
        REG_FRAME_HEIGHT = 2'd1,
        REG_PACK_ORDER   = 2'd2
    } cfg_reg_t;

    // Byte orders of the packed word
    localparam logic PACK_ARGB = 1'b0;
    localparam logic PACK_RGBA = 1'b1;

    // Reset values of the configuration registers
    localparam logic [DIM_W-1:0] FRAME_WIDTH_RST  = 9'd256;
    localparam logic [DIM_W-1:0] FRAME_HEIGHT_RST = 9'd256;
    localparam logic             PACK_ORDER_RST   = PACK_ARGB;

    localparam logic [BYTE_W-1:0] ALPHA_LEVEL = 8'hFF;
    localparam logic [BYTE_W-1:0] SAT_LEVEL   = 8'hFF;

endpackage

FILE: hdl/frame_peak_normalize_pack_core.sv
// Frame peak normalizer core: RGB frame store, peak scan and 8-bit packing.
// Depends on fpnp_pkg.
//
// One item is taken at a time; s_tready is high whenever the core is idle, even
// while a finished result still sits in the output register. A write goes
// straight to the output step. An in-range read runs one memory read, one load,
// the shared bit-serial divider (one quotient bit per cycle, three channel lanes
// in parallel against the peak), one pack step and one output step. A scan
// walks the frame one pixel per cycle through the single read port of the three
// channel memories. An empty frame skips the walk and sets the peak to zero.
// The stores come up undefined; no clearing pass runs after reset. The peak is
// zero after reset and changes only on a scan.
module frame_peak_normalize_pack_core #(
    parameter int MAX_WIDTH    = fpnp_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT   = fpnp_pkg::MAX_HEIGHT_DEF,
    parameter int CHANNEL_BITS = fpnp_pkg::CHANNEL_BITS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // Input items
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // pixel_x[7:0], pixel_y[15:8], red_value[31:16], green_value[47:32],
    // blue_value[63:48]
    input  logic [fpnp_pkg::S_TDATA_W-1:0]     s_tdata,
    // func[1:0]
    input  logic [fpnp_pkg::FUNC_W-1:0]        s_tuser,
    // Results
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // pixel_word[31:0], peak_level[47:32]
    output logic [fpnp_pkg::M_TDATA_W-1:0]     m_tdata,
    // status[1:0]
    output logic [fpnp_pkg::STATUS_W-1:0]      m_tuser,
    // Configuration writes
    input  logic                               cfg_we,
    input  logic [fpnp_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [fpnp_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int AX        = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int AY        = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int AW        = AX + AY;
    localparam int MEM_DEPTH = 1 << AW;
    localparam int CB        = CHANNEL_BITS;
    localparam int NUM_W     = CB + fpnp_pkg::QUOT_W;
    localparam int REM_W     = NUM_W + 1;
    localparam int LANES     = 3;
    localparam int DW        = fpnp_pkg::DIM_W;
    localparam int EW        = fpnp_pkg::DIM_EXT_W;

    localparam logic [EW-1:0] MAX_W_EXT = EW'(MAX_WIDTH);
    localparam logic [EW-1:0] MAX_H_EXT = EW'(MAX_HEIGHT);
    localparam logic [2:0]    DIV_LAST  = 3'(fpnp_pkg::QUOT_W - 1);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_SCAN  = 7'b0000010,
        S_DRAIN = 7'b0000100,
        S_LOAD  = 7'b0001000,
        S_DIV   = 7'b0010000,
        S_PACK  = 7'b0100000,
        S_OUT   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    // Configuration
    logic [DW-1:0] fw_reg, fw_next;
    logic [DW-1:0] fh_reg, fh_next;
    logic          order_reg, order_next;

    // Peak, scan walk
    logic [CB-1:0] peak_reg, peak_next;
    logic [CB-1:0] scan_max_reg, scan_max_next;
    logic [DW-1:0] col_reg, col_next;
    logic [DW-1:0] row_reg, row_next;
    logic          rd_vld_reg, rd_vld_next;

    // Divider lanes
    logic [REM_W-1:0]              rem_reg [LANES];
    logic [REM_W-1:0]              rem_next [LANES];
    logic [fpnp_pkg::QUOT_W-1:0]   q_reg [LANES];
    logic [fpnp_pkg::QUOT_W-1:0]   q_next [LANES];
    logic [LANES-1:0]              sat_reg, sat_next;
    logic [2:0]                    cnt_reg, cnt_next;

    // Pending result and output register
    logic [fpnp_pkg::WORD_W-1:0]   res_word_reg, res_word_next;
    fpnp_pkg::status_t             res_status_reg, res_status_next;
    logic                          m_valid_reg, m_valid_next;
    logic [fpnp_pkg::WORD_W-1:0]   m_word_reg, m_word_next;
    logic [fpnp_pkg::PEAK_W-1:0]   m_peak_reg, m_peak_next;
    fpnp_pkg::status_t             m_status_reg, m_status_next;

    // Channel memories
    logic [CB-1:0] red_mem   [MEM_DEPTH];
    logic [CB-1:0] green_mem [MEM_DEPTH];
    logic [CB-1:0] blue_mem  [MEM_DEPTH];
    logic [CB-1:0] rd_data_reg [LANES];

    // Input beat fields
    fpnp_pkg::func_t                  in_func;
    logic [fpnp_pkg::COORD_W-1:0]     in_x, in_y;
    logic [fpnp_pkg::CHAN_EXT_W-1:0]  val_ext [LANES];
    logic [CB-1:0]                    wr_val [LANES];
    logic                             s_accept;

    logic [DW-1:0] cols, rows;
    logic [EW-1:0] fw_ext, fh_ext, x_ext, y_ext, col_ext, row_ext;
    logic          in_range;
    logic [AW-1:0] in_addr, scan_addr, rd_addr;
    logic          mem_we;

    logic [CB-1:0]               max_cand;
    logic [REM_W-1:0]            d_val;
    logic [REM_W-1:0]            num [LANES];
    logic [REM_W-1:0]            shifted [LANES];
    logic [LANES-1:0]            ge;
    logic [fpnp_pkg::BYTE_W-1:0] chan [LANES];
    logic [fpnp_pkg::WORD_W-1:0] packed_word;
    logic [fpnp_pkg::CHAN_EXT_W-1:0] peak_ext;
    logic                        out_free;

    assign in_func    = fpnp_pkg::func_t'(s_tuser);
    assign in_x       = s_tdata[7:0];
    assign in_y       = s_tdata[15:8];
    assign val_ext[0] = fpnp_pkg::CHAN_EXT_W'(s_tdata[31:16]);
    assign val_ext[1] = fpnp_pkg::CHAN_EXT_W'(s_tdata[47:32]);
    assign val_ext[2] = fpnp_pkg::CHAN_EXT_W'(s_tdata[63:48]);
    assign wr_val[0]  = val_ext[0][CB-1:0];
    assign wr_val[1]  = val_ext[1][CB-1:0];
    assign wr_val[2]  = val_ext[2][CB-1:0];

    assign s_tready = (state_reg == S_IDLE);
    assign s_accept = s_tvalid && s_tready;

    // Active frame size, clamped to the store size
    assign fw_ext   = EW'(fw_reg);
    assign fh_ext   = EW'(fh_reg);
    assign cols     = (fw_ext > MAX_W_EXT) ? MAX_W_EXT[DW-1:0] : fw_reg;
    assign rows     = (fh_ext > MAX_H_EXT) ? MAX_H_EXT[DW-1:0] : fh_reg;
    assign in_range = ({1'b0, in_x} < cols) && ({1'b0, in_y} < rows);

    // Store addresses: row in the high bits, column in the low bits
    assign x_ext     = EW'(in_x);
    assign y_ext     = EW'(in_y);
    assign col_ext   = EW'(col_reg);
    assign row_ext   = EW'(row_reg);
    assign in_addr   = {y_ext[AY-1:0], x_ext[AX-1:0]};
    assign scan_addr = {row_ext[AY-1:0], col_ext[AX-1:0]};
    assign rd_addr   = (state_reg == S_SCAN) ? scan_addr : in_addr;
    assign mem_we    = s_accept && (in_func == fpnp_pkg::FUNC_WRITE) && in_range;

    // Memories: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            red_mem[in_addr]   <= wr_val[0];
            green_mem[in_addr] <= wr_val[1];
            blue_mem[in_addr]  <= wr_val[2];
        end
        rd_data_reg[0] <= red_mem[rd_addr];
        rd_data_reg[1] <= green_mem[rd_addr];
        rd_data_reg[2] <= blue_mem[rd_addr];
    end

    // Running maximum over the three channels of the pixel just read
    always_comb begin
        max_cand = scan_max_reg;
        for (int i = 0; i < LANES; i++) begin
            if (rd_data_reg[i] > max_cand) begin
                max_cand = rd_data_reg[i];
            end
        end
    end

    // Divider datapath: value*255 = (value << 8) - value, divisor = peak << 8
    assign d_val = {1'b0, peak_reg, {fpnp_pkg::QUOT_W{1'b0}}};
    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            num[i]     = REM_W'({rd_data_reg[i], {fpnp_pkg::QUOT_W{1'b0}}}
                                - NUM_W'(rd_data_reg[i]));
            shifted[i] = {rem_reg[i][REM_W-2:0], 1'b0};
            ge[i]      = (shifted[i] >= d_val);
            if (peak_reg == '0) begin
                chan[i] = '0;
            end else if (sat_reg[i]) begin
                chan[i] = fpnp_pkg::SAT_LEVEL;
            end else begin
                chan[i] = q_reg[i];
            end
        end
    end

    assign packed_word = (order_reg == fpnp_pkg::PACK_RGBA)
        ? {chan[0], chan[1], chan[2], fpnp_pkg::ALPHA_LEVEL}
        : {fpnp_pkg::ALPHA_LEVEL, chan[0], chan[1], chan[2]};

    assign peak_ext = fpnp_pkg::CHAN_EXT_W'(peak_reg);
    assign out_free = !m_valid_reg || m_tready;

    // Next-state logic
    always_comb begin
        state_next      = state_reg;
        fw_next         = fw_reg;
        fh_next         = fh_reg;
        order_next      = order_reg;
        peak_next       = peak_reg;
        scan_max_next   = scan_max_reg;
        col_next        = col_reg;
        row_next        = row_reg;
        rd_vld_next     = 1'b0;
        cnt_next        = cnt_reg;
        sat_next        = sat_reg;
        res_word_next   = res_word_reg;
        res_status_next = res_status_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        m_word_next     = m_word_reg;
        m_peak_next     = m_peak_reg;
        m_status_next   = m_status_reg;
        for (int i = 0; i < LANES; i++) begin
            rem_next[i] = rem_reg[i];
            q_next[i]   = q_reg[i];
        end

        // Configuration writes
        if (cfg_we) begin
            unique case (fpnp_pkg::cfg_reg_t'(cfg_index))
                fpnp_pkg::REG_FRAME_WIDTH:  fw_next    = cfg_data;
                fpnp_pkg::REG_FRAME_HEIGHT: fh_next    = cfg_data;
                fpnp_pkg::REG_PACK_ORDER:   order_next = cfg_data[0];
                default: ;
            endcase
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    res_word_next   = '0;
                    res_status_next = fpnp_pkg::STATUS_OK;
                    unique case (in_func)
                        fpnp_pkg::FUNC_WRITE: begin
                            if (!in_range) begin
                                res_status_next = fpnp_pkg::STATUS_RANGE;
                            end
                            state_next = S_OUT;
                        end
                        fpnp_pkg::FUNC_SCAN: begin
                            scan_max_next = '0;
                            col_next      = '0;
                            row_next      = '0;
                            if (cols == '0 || rows == '0) begin
                                peak_next  = '0;
                                state_next = S_OUT;
                            end else begin
                                state_next = S_SCAN;
                            end
                        end
                        fpnp_pkg::FUNC_READ: begin
                            if (!in_range) begin
                                res_status_next = fpnp_pkg::STATUS_RANGE;
                                state_next      = S_OUT;
                            end else begin
                                state_next = S_LOAD;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_SCAN: begin
                // one pixel read per cycle, max taken in the next cycle
                rd_vld_next = 1'b1;
                if (rd_vld_reg) begin
                    scan_max_next = max_cand;
                end
                if ((col_reg + 9'd1) == cols) begin
                    col_next = '0;
                    row_next = row_reg + 9'd1;
                    if ((row_reg + 9'd1) == rows) begin
                        state_next = S_DRAIN;
                    end
                end else begin
                    col_next = col_reg + 9'd1;
                end
            end
            S_DRAIN: begin
                peak_next  = max_cand;
                state_next = S_OUT;
            end
            S_LOAD: begin
                for (int i = 0; i < LANES; i++) begin
                    rem_next[i] = num[i];
                    q_next[i]   = '0;
                    sat_next[i] = (num[i] >= d_val);
                end
                cnt_next   = '0;
                state_next = S_DIV;
            end
            S_DIV: begin
                // restoring division, one quotient bit per lane per cycle
                for (int i = 0; i < LANES; i++) begin
                    rem_next[i] = ge[i] ? (shifted[i] - d_val) : shifted[i];
                    q_next[i]   = {q_reg[i][fpnp_pkg::QUOT_W-2:0], ge[i]};
                end
                cnt_next = cnt_reg + 3'd1;
                if (cnt_reg == DIV_LAST) begin
                    state_next = S_PACK;
                end
            end
            S_PACK: begin
                res_word_next   = packed_word;
                res_status_next = (peak_reg == '0) ? fpnp_pkg::STATUS_PEAK_ZERO
                                                   : fpnp_pkg::STATUS_OK;
                state_next      = S_OUT;
            end
            S_OUT: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_word_next   = res_word_reg;
                    m_peak_next   = peak_ext[fpnp_pkg::PEAK_W-1:0];
                    m_status_next = res_status_reg;
                    state_next    = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            fw_reg      <= fpnp_pkg::FRAME_WIDTH_RST;
            fh_reg      <= fpnp_pkg::FRAME_HEIGHT_RST;
            order_reg   <= fpnp_pkg::PACK_ORDER_RST;
            peak_reg    <= '0;
            rd_vld_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            fw_reg      <= fw_next;
            fh_reg      <= fh_next;
            order_reg   <= order_next;
            peak_reg    <= peak_next;
            rd_vld_reg  <= rd_vld_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        scan_max_reg   <= scan_max_next;
        col_reg        <= col_next;
        row_reg        <= row_next;
        cnt_reg        <= cnt_next;
        sat_reg        <= sat_next;
        res_word_reg   <= res_word_next;
        res_status_reg <= res_status_next;
        m_word_reg     <= m_word_next;
        m_peak_reg     <= m_peak_next;
        m_status_reg   <= m_status_next;
        for (int i = 0; i < LANES; i++) begin
            rem_reg[i] <= rem_next[i];
            q_reg[i]   <= q_next[i];
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_peak_reg, m_word_reg};
    assign m_tuser  = m_status_reg;

endmodule

FILE: hdl/fpnp_checker.sv
// Port checker for the frame peak normalizer core, bound to the top level.
// Depends on fpnp_pkg and frame_peak_normalize_pack_core_defines.svh.
`include "frame_peak_normalize_pack_core_defines.svh"

module fpnp_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [fpnp_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [fpnp_pkg::STATUS_W-1:0]  m_tuser
);

    // A stalled result beat holds its payload
    `FPNP_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result beat changed while stalled")

    // Out-of-range coordinates give an empty pixel word
    `FPNP_ASSERT_IMPLY(a_range_word, aclk, aresetn, m_tvalid && (m_tuser == fpnp_pkg::STATUS_RANGE), m_tdata[31:0] == 32'h0, "range status with nonzero pixel word")

    // Zero peak: peak reads zero and only the alpha byte is set
    `FPNP_ASSERT_IMPLY(a_peak_zero, aclk, aresetn, m_tvalid && (m_tuser == fpnp_pkg::STATUS_PEAK_ZERO), (m_tdata[47:32] == 16'h0) && ((m_tdata[31:0] == 32'hFF000000) || (m_tdata[31:0] == 32'h000000FF)), "peak-zero result malformed")

    // Any nonzero word carries alpha in the top or bottom byte
    `FPNP_ASSERT_IMPLY(a_alpha, aclk, aresetn, m_tvalid && (m_tuser == fpnp_pkg::STATUS_OK) && (m_tdata[31:0] != 32'h0), (m_tdata[31:24] == 8'hFF) || (m_tdata[7:0] == 8'hFF), "packed pixel lacks alpha")

endmodule

bind frame_peak_normalize_pack_core fpnp_checker u_fpnp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
